FILE: hw/rtl/itor_pkg.sv
package itor_pkg;

  // format kinds
  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_OCT  = 2'd3;

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'hA: c = 7'h41;
      4'hB: c = 7'h42;
      4'hC: c = 7'h43;
      4'hD: c = 7'h44;
      4'hE: c = 7'h45;
      default: c = 7'h46;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/itor_front.sv
module itor_front import itor_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  input  q_status_t              q_status,
  output logic                   q_push,
  output logic [WORD_BITS+2:0]   q_wdata
);

  logic [WORD_BITS-1:0] word;
  logic                 neg;
  logic [WORD_BITS-1:0] mag;

  // bits above the word width are dropped, narrower input is zero-extended
  assign word = WORD_BITS'(in_data.value);
  assign neg  = (in_data.kind != KIND_UDEC) && word[WORD_BITS-1];
  assign mag  = neg ? (~word + WORD_BITS'(1)) : word;

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;
  assign q_wdata  = {in_data.kind, neg, mag};

endmodule

FILE: hw/rtl/itor_queue.sv
module itor_queue import itor_pkg::*; #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_status_t        status
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  assign rdata        = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/itor_back.sv
module itor_back import itor_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  q_status_t            q_status,
  input  logic [WORD_BITS+2:0] q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  // enough digit slots for octal, which always needs the most
  localparam int ND = (WORD_BITS + 2) / 3;
  localparam int DW = ND * 4;
  localparam int OW = ND * 3;
  localparam int CW = $clog2(WORD_BITS + 1);
  localparam int RW = $clog2(ND + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_PFX0  = 3'd3;
  localparam logic [2:0] ST_PFXX  = 3'd4;
  localparam logic [2:0] ST_DIGS  = 3'd5;
  localparam logic [2:0] ST_SPACE = 3'd6;

  logic [2:0]           state_r,     state_nxt;
  logic [1:0]           kind_r,      kind_nxt;
  logic                 neg_r,       neg_nxt;
  logic [WORD_BITS-1:0] mag_r,       mag_nxt;
  logic [DW-1:0]        dig_r,       dig_nxt;
  logic [CW-1:0]        cnt_r,       cnt_nxt;
  logic [RW-1:0]        rem_r,       rem_nxt;
  logic                 seen_r,      seen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r,  out_data_nxt;

  logic [1:0]           e_kind;
  logic                 e_neg;
  logic [WORD_BITS-1:0] e_mag;
  logic [DW-1:0]        hex_vec;
  logic [OW-1:0]        oct_pad;
  logic [DW-1:0]        oct_vec;
  logic [DW-1:0]        adj_vec;
  logic [3:0]           top_dig;
  logic                 slot_free;
  logic                 emit;
  logic [6:0]           emit_char;
  logic                 emit_last;

  assign e_kind = q_rdata[WORD_BITS+2:WORD_BITS+1];
  assign e_neg  = q_rdata[WORD_BITS];
  assign e_mag  = q_rdata[WORD_BITS-1:0];

  assign hex_vec = DW'(e_mag);
  assign oct_pad = OW'(e_mag);

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      oct_vec[4*i +: 4] = {1'b0, oct_pad[3*i +: 3]};
      // shift-and-add-3 correction per BCD digit
      if (dig_r[4*i +: 4] >= 4'd5) begin
        adj_vec[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        adj_vec[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  assign top_dig   = dig_r[DW-1 -: 4];
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    seen_nxt  = seen_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_SPACE;
    emit_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop    = 1'b1;
          kind_nxt = e_kind;
          neg_nxt  = e_neg;
          mag_nxt  = e_mag;
          rem_nxt  = RW'(ND);
          seen_nxt = 1'b0;
          cnt_nxt  = CW'(WORD_BITS);
          if (e_kind == KIND_HEX) begin
            dig_nxt   = hex_vec;
            state_nxt = ST_SIGN;
          end else if (e_kind == KIND_OCT) begin
            dig_nxt   = oct_vec;
            state_nxt = ST_SIGN;
          end else begin
            dig_nxt   = '0;
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dig_nxt = {adj_vec[DW-2:0], mag_r[WORD_BITS-1]};
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!neg_r) begin
          state_nxt = ST_PFX0;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = CHAR_MINUS;
          state_nxt = ST_PFX0;
        end
      end
      ST_PFX0: begin
        if (!(kind_r inside {KIND_HEX, KIND_OCT})) begin
          state_nxt = ST_DIGS;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = CHAR_ZERO;
          state_nxt = (kind_r == KIND_HEX) ? ST_PFXX : ST_DIGS;
        end
      end
      ST_PFXX: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CHAR_X;
          state_nxt = ST_DIGS;
        end
      end
      ST_DIGS: begin
        // drop leading zeros, but always keep the last digit
        if (!seen_r && top_dig == 4'd0 && rem_r > RW'(1)) begin
          dig_nxt = dig_r << 4;
          rem_nxt = rem_r - RW'(1);
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = digit_char(top_dig);
          seen_nxt  = 1'b1;
          dig_nxt   = dig_r << 4;
          rem_nxt   = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = ST_SPACE;
          end
        end
      end
      ST_SPACE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CHAR_SPACE;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.character = emit_char;
      out_data_nxt.last      = emit_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    seen_r     <= seen_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/integer_to_ascii_radix.sv
// Channel  Ports                          Moves
// input    in_valid/in_stall/in_data      kind + 32-bit word, one item per number
// output   out_valid/out_stall/out_data   one ASCII character per item, last on space
//
// Each item is popped; decimal items then run the shift-and-add-3 loop over
// every word bit, and all go on through sign, prefix, digit scan and the space.
// Hex and octal skip the loop.
// A two-entry queue lets up to two items wait while the back end works.
// Reset is synchronous, active low; it empties the queue and the output.
// Output stalls hold the character register and pause emission; leading-zero skipping goes on.
module integer_to_ascii_radix import itor_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int QW = WORD_BITS + 3;

  q_status_t     q_status;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  itor_front #(.WORD_BITS(WORD_BITS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  itor_queue #(.WIDTH(QW)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  itor_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/tb.sv
module tb;
  import itor_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 295;
  localparam int QUIET_ITEMS = 60;
  localparam int SETTLE_CYCLES = 80;

  // Expected characters of every number taken in, oldest first
  class char_ledger;
    out_item_t awaited_chars[$];
    int        errors;
    int        chars_seen;
    int        kind_seen[4];
    string     digit_glyphs = "0123456789ABCDEF";

    function void push_char(logic [6:0] c, logic l);
      out_item_t e;
      e.character = c;
      e.last      = l;
      awaited_chars.push_back(e);
    endfunction

    // Sign-magnitude for every kind but unsigned decimal
    function void note_number(in_item_t it);
      logic [31:0] mag;
      logic [31:0] radix;
      logic        neg;
      int          digits[$];
      neg = (it.kind != KIND_UDEC) && it.value[31];
      mag = neg ? (~it.value + 32'd1) : it.value;
      case (it.kind)
        KIND_HEX: radix = 32'd16;
        KIND_OCT: radix = 32'd8;
        default:  radix = 32'd10;
      endcase
      if (mag == 32'd0) digits.push_back(0);
      while (mag != 32'd0) begin
        digits.push_back(int'(mag % radix));
        mag = mag / radix;
      end
      if (neg) push_char(CHAR_MINUS, 1'b0);
      if (it.kind == KIND_HEX) begin
        push_char(CHAR_ZERO, 1'b0);
        push_char(CHAR_X, 1'b0);
      end else if (it.kind == KIND_OCT) begin
        push_char(CHAR_ZERO, 1'b0);
      end
      for (int i = digits.size() - 1; i >= 0; i--)
        push_char(7'(digit_glyphs[digits[i]]), 1'b0);
      push_char(CHAR_SPACE, 1'b1);
      kind_seen[it.kind]++;
    endfunction

    task flag_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_char(out_item_t got);
      out_item_t want;
      chars_seen++;
      if (awaited_chars.size() == 0) begin
        flag_error($sformatf("character %h arrived with none awaited", got.character));
      end else begin
        want = awaited_chars.pop_front();
        if (got.character !== want.character)
          flag_error($sformatf("character %h, wanted %h", got.character, want.character));
        if (got.last !== want.last)
          flag_error($sformatf("last %b on character %h, wanted %b",
                               got.last, got.character, want.last));
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  char_ledger ledger = new();
  bit         quiet;
  bit         hold_req;
  bit         hold_served;
  int         cycle_count;

  integer_to_ascii_radix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
  end

  always #5 clk = ~clk;

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.note_number(in_data);
      if (out_valid && !out_stall) ledger.check_char(out_data);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("integer_to_ascii_radix: mismatch");
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request, none when quiet
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        repeat (n) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  task send_number(logic [1:0] kind, logic [31:0] value);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data.kind  <= kind;
    in_data.value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 999));
      1:       return -32'($urandom_range(1, 999));
      2:       return 32'd1 << k;
      3:       return (32'd1 << k) - 32'd1;
      4:       return 32'h8000_0000 ^ 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] corners[5];
    int          waited;
    corners = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Each kind at the corners: zero, one, most positive, most negative, all ones
    foreach (corners[i]) begin
      send_number(KIND_UDEC, corners[i]);
      send_number(KIND_SDEC, corners[i]);
      send_number(KIND_HEX, corners[i]);
      send_number(KIND_OCT, corners[i]);
    end
    send_number(KIND_HEX, 32'h0ABC_DEF9);
    send_number(KIND_UDEC, 32'd1000000000);
    send_number(KIND_OCT, 32'o1234567);

    // Hold the output off long enough for the input to back up
    hold_req = 1'b1;
    repeat (12) send_number(2'($urandom_range(0, 3)), pick_value());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 13));
      send_number(2'($urandom_range(0, 3)), pick_value());
    end
    idle_input(1);

    while (ledger.awaited_chars.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < SETTLE_CYCLES) begin
      @(posedge clk);
      waited++;
    end

    $display("covered %0d unsigned, %0d signed, %0d hex and %0d octal numbers",
             ledger.kind_seen[KIND_UDEC], ledger.kind_seen[KIND_SDEC],
             ledger.kind_seen[KIND_HEX], ledger.kind_seen[KIND_OCT]);
    $display("checked %0d characters, one output hold of %0d cycles, %0d errors",
             ledger.chars_seen, HOLD_CYCLES, ledger.errors);
    if (ledger.errors == 0 && ledger.awaited_chars.size() == 0) begin
      $display("integer_to_ascii_radix: match");
    end else begin
      $display("integer_to_ascii_radix: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/itor_pkg.sv
hw/rtl/itor_front.sv
hw/rtl/itor_queue.sv
hw/rtl/itor_back.sv
hw/rtl/integer_to_ascii_radix.sv
verif/tb.sv
